### hdl/pkrms_pkg.sv
// ----------------------------------------------------------------------------
// pkrms_pkg
// Shared constants, codes and control structs of the peak/RMS meter.
// ----------------------------------------------------------------------------
package pkrms_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 3;
    localparam int COEF_W   = 16;
    localparam int PEAK_W   = 16;
    localparam int MSQ_W    = 31;
    localparam int LEVEL_W  = 16;
    localparam int DECIM_W  = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 2'd2;

    localparam logic [COEF_W-1:0] ATTACK_RESET  = 16'd65535;
    localparam logic [COEF_W-1:0] RELEASE_RESET = 16'd655;
    localparam logic [COEF_W-1:0] PERIOD_RESET  = 16'd1;

    localparam logic [1:0] MUL_SQ = 2'd0;
    localparam logic [1:0] MUL_PK = 2'd1;
    localparam logic [1:0] MUL_MS = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic [1:0] mul_sel;
        logic       cap_sq;
        logic       upd_pk;
        logic       commit;
        logic       sqrt_start;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic emit;
        logic sqrt_busy;
    } status_t;

endpackage

### hdl/pkrms_ram.sv
// ----------------------------------------------------------------------------
// pkrms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkrms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/pkrms_sqrt.sv
// ----------------------------------------------------------------------------
// pkrms_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pkrms_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value,
    output logic        busy,
    output logic [15:0] root
);

    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] val_reg, val_next;
    logic [19:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;
    logic [19:0] rem_shift;
    logic [19:0] trial;

    always_comb
    begin
        rem_shift = {rem_reg[17:0], val_reg[31:30]};
        trial     = {2'b00, root_reg, 2'b01};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            val_next  = value;
            rem_next  = 20'd0;
            root_next = 16'd0;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[29:0], 2'b00};
            cnt_next = cnt_reg + 4'd1;
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[14:0], 1'b0};
            end
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### hdl/pkrms_datapath.sv
// ----------------------------------------------------------------------------
// pkrms_datapath
// Envelope store, shared multiplier, frame maxima, decimation and readout.
// ----------------------------------------------------------------------------
module pkrms_datapath #(
    parameter int NUM_CHANNELS = pkrms_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pkrms_pkg::cmd_t                     cmd,
    output pkrms_pkg::status_t                  status,
    input  logic signed [pkrms_pkg::SAMPLE_W-1:0] sample,
    input  logic [pkrms_pkg::CHAN_W-1:0]        channel,
    input  logic                                frame_last,
    input  logic                                cfg_we,
    input  logic [pkrms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pkrms_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [pkrms_pkg::LEVEL_W-1:0]       peak_level,
    output logic [pkrms_pkg::LEVEL_W-1:0]       rms_level
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ENV_W = pkrms_pkg::PEAK_W + pkrms_pkg::MSQ_W;

    logic [pkrms_pkg::COEF_W-1:0]  attack_reg, release_reg, period_reg;

    logic [pkrms_pkg::PEAK_W-1:0]  mag_reg;
    logic [pkrms_pkg::CHAN_W-1:0]  ch_reg;
    logic                          last_reg;
    logic [pkrms_pkg::MSQ_W-1:0]   sq_reg;
    logic signed [48:0]            prod_reg;
    logic [pkrms_pkg::PEAK_W-1:0]  pk_new_reg;
    logic [NUM_CHANNELS-1:0]       valid_reg, valid_next;
    logic                          rd_valid_reg;
    logic [pkrms_pkg::PEAK_W-1:0]  max_pk_reg, max_pk_next;
    logic [pkrms_pkg::MSQ_W-1:0]   max_ms_reg, max_ms_next;
    logic signed [pkrms_pkg::DECIM_W-1:0] decim_reg, decim_next;
    logic                          open_reg, open_next;
    logic [pkrms_pkg::LEVEL_W-1:0] peak_out_reg, rms_out_reg;

    logic [16:0]                   neg_sample;
    logic [pkrms_pkg::PEAK_W-1:0]  mag_in;
    logic [CH_W-1:0]               ch_idx;
    logic                          in_range;
    logic [ENV_W-1:0]              ram_rdata, ram_wdata;
    logic [pkrms_pkg::PEAK_W-1:0]  pk_env;
    logic [pkrms_pkg::MSQ_W-1:0]   ms_env, ms_new;
    logic signed [16:0]            pk_diff;
    logic signed [31:0]            ms_diff;
    logic [pkrms_pkg::COEF_W-1:0]  pk_coef, ms_coef;
    logic signed [31:0]            op_a;
    logic signed [16:0]            op_b;
    logic signed [48:0]            mul_out;
    logic signed [32:0]            step;
    logic signed [33:0]            pk_sum, ms_sum;
    logic [pkrms_pkg::PEAK_W-1:0]  base_pk;
    logic [pkrms_pkg::MSQ_W-1:0]   base_ms;
    logic signed [pkrms_pkg::DECIM_W-1:0] decim_m1, period_ext;
    logic                          sqrt_busy;
    logic [15:0]                   sqrt_root;

    assign neg_sample = 17'h10000 - {1'b0, sample};
    assign mag_in     = sample[pkrms_pkg::SAMPLE_W-1] ? neg_sample[15:0] : sample;
    assign ch_idx     = CH_W'(ch_reg);
    assign in_range   = ({29'd0, ch_reg} < NUM_CHANNELS);

    assign pk_env = rd_valid_reg ? ram_rdata[ENV_W-1:pkrms_pkg::MSQ_W] : '0;
    assign ms_env = rd_valid_reg ? ram_rdata[pkrms_pkg::MSQ_W-1:0] : '0;

    assign pk_diff = $signed({1'b0, mag_reg}) - $signed({1'b0, pk_env});
    assign ms_diff = $signed({1'b0, sq_reg}) - $signed({1'b0, ms_env});
    assign pk_coef = (mag_reg > pk_env) ? attack_reg : release_reg;
    assign ms_coef = (sq_reg > ms_env) ? attack_reg : release_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            pkrms_pkg::MUL_SQ:
            begin
                op_a = $signed({16'd0, mag_reg});
                op_b = $signed({1'b0, mag_reg});
            end
            pkrms_pkg::MUL_PK:
            begin
                op_a = {{15{pk_diff[16]}}, pk_diff};
                op_b = $signed({1'b0, pk_coef});
            end
            pkrms_pkg::MUL_MS:
            begin
                op_a = ms_diff;
                op_b = $signed({1'b0, ms_coef});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_out = op_a * op_b;
    assign step    = 33'(prod_reg >>> 16);
    assign pk_sum  = $signed({18'd0, pk_env}) + {step[32], step};
    assign ms_sum  = $signed({3'd0, ms_env}) + {step[32], step};
    assign ms_new  = ms_sum[pkrms_pkg::MSQ_W-1:0];

    assign ram_wdata = {pk_new_reg, ms_new};

    assign base_pk = open_reg ? max_pk_reg : '0;
    assign base_ms = open_reg ? max_ms_reg : '0;

    assign decim_m1   = decim_reg - 17'sd1;
    assign period_ext = (period_reg == '0) ? 17'sd1 : $signed({1'b0, period_reg});

    always_comb
    begin
        valid_next  = valid_reg;
        max_pk_next = max_pk_reg;
        max_ms_next = max_ms_reg;
        decim_next  = decim_reg;
        open_next   = open_reg;
        if (cmd.commit)
        begin
            max_pk_next = base_pk;
            max_ms_next = base_ms;
            if (in_range)
            begin
                valid_next[ch_idx] = 1'b1;
                if (pk_new_reg > base_pk)
                begin
                    max_pk_next = pk_new_reg;
                end
                if (ms_new > base_ms)
                begin
                    max_ms_next = ms_new;
                end
            end
            open_next = !last_reg;
            if (last_reg)
            begin
                decim_next = (decim_m1 <= 17'sd0) ? decim_m1 + period_ext : decim_m1;
            end
        end
    end

    pkrms_ram #(
        .WIDTH (ENV_W),
        .DEPTH (NUM_CHANNELS),
        .ADDR_W(CH_W)
    ) u_env_ram (
        .clk  (clk),
        .we   (cmd.commit && in_range),
        .waddr(ch_idx),
        .wdata(ram_wdata),
        .raddr(ch_idx),
        .rdata(ram_rdata)
    );

    pkrms_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.sqrt_start),
        .value({1'b0, max_ms_reg}),
        .busy (sqrt_busy),
        .root (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg   <= pkrms_pkg::ATTACK_RESET;
            release_reg  <= pkrms_pkg::RELEASE_RESET;
            period_reg   <= pkrms_pkg::PERIOD_RESET;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            max_pk_reg   <= '0;
            max_ms_reg   <= '0;
            decim_reg    <= '0;
            open_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pkrms_pkg::REG_ATTACK_COEF:   attack_reg  <= cfg_data;
                    pkrms_pkg::REG_RELEASE_COEF:  release_reg <= cfg_data;
                    pkrms_pkg::REG_UPDATE_PERIOD: period_reg  <= cfg_data;
                    default:                      ;
                endcase
            end
            valid_reg    <= valid_next;
            rd_valid_reg <= in_range ? valid_reg[ch_idx] : 1'b0;
            max_pk_reg   <= max_pk_next;
            max_ms_reg   <= max_ms_next;
            decim_reg    <= decim_next;
            open_reg     <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mag_reg  <= mag_in;
            ch_reg   <= channel;
            last_reg <= frame_last;
        end
        prod_reg <= mul_out;
        if (cmd.cap_sq)
        begin
            sq_reg <= prod_reg[pkrms_pkg::MSQ_W-1:0];
        end
        if (cmd.upd_pk)
        begin
            pk_new_reg <= pk_sum[pkrms_pkg::PEAK_W-1:0];
        end
        if (cmd.load_out)
        begin
            peak_out_reg <= max_pk_reg;
            rms_out_reg  <= sqrt_root;
        end
    end

    assign status.last      = last_reg;
    assign status.emit      = (decim_reg <= 17'sd1);
    assign status.sqrt_busy = sqrt_busy;

    assign peak_level = peak_out_reg;
    assign rms_level  = rms_out_reg;

endmodule

### hdl/pkrms_ctrl.sv
// ----------------------------------------------------------------------------
// pkrms_ctrl
// Sequencer: input handshake, envelope update steps, root and output word.
// ----------------------------------------------------------------------------
module pkrms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pkrms_pkg::status_t status,
    output pkrms_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_PK   = 3'd2;
    localparam logic [2:0] ST_MS   = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_SQS  = 3'd5;
    localparam logic [2:0] ST_SQW  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       ready;
    logic       accept;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: ready = 1'b1;
            ST_WR:   ready = !(status.last && status.emit);
            default: ready = 1'b0;
        endcase
    end

    assign accept = in_valid && ready;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = pkrms_pkg::MUL_SQ;
        cmd.load_in    = accept;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.mul_sel = pkrms_pkg::MUL_SQ;
                state_next  = ST_PK;
            end
            ST_PK:
            begin
                cmd.mul_sel = pkrms_pkg::MUL_PK;
                cmd.cap_sq  = 1'b1;
                state_next  = ST_MS;
            end
            ST_MS:
            begin
                cmd.mul_sel = pkrms_pkg::MUL_MS;
                cmd.upd_pk  = 1'b1;
                state_next  = ST_WR;
            end
            ST_WR:
            begin
                cmd.commit = 1'b1;
                if (status.last && status.emit)
                begin
                    state_next = ST_SQS;
                end
                else if (accept)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQS:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQW;
            end
            ST_SQW:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = ready;
    assign out_valid = out_valid_reg;

endmodule

### hdl/multichannel_peak_rms_meter_core.sv
// ----------------------------------------------------------------------------
// multichannel_peak_rms_meter_core
// Per-channel attack/release peak and mean-square envelopes with frame
// maxima and decimated peak/RMS readings.
//
//   channel   handshake             word
//   -------   -------------------   ------------------------------------
//   input     in_valid / in_ready   sample, channel, frame_last
//   output    out_valid / out_ready peak_level, rms_level
//   config    cfg_we                cfg_index, cfg_data
//
// An input word passes through envelope read and square, peak step,
// mean-square step and write-back, sharing one multiplier; the next word
// is taken in the write-back state unless a frame end emits a reading,
// which adds the bit-serial square root and the output load.
// Reset clears all envelopes (per-channel valid bits), maxima and counters.
// A pending output word holds until taken; a new reading waits for it.
// ----------------------------------------------------------------------------
module multichannel_peak_rms_meter_core #(
    parameter int NUM_CHANNELS = pkrms_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pkrms_pkg::SAMPLE_W-1:0] sample,
    input  logic [pkrms_pkg::CHAN_W-1:0]          channel,
    input  logic                                  frame_last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pkrms_pkg::LEVEL_W-1:0]         peak_level,
    output logic [pkrms_pkg::LEVEL_W-1:0]         rms_level,
    input  logic                                  cfg_we,
    input  logic [pkrms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pkrms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pkrms_pkg::cmd_t    cmd;
    pkrms_pkg::status_t status;

    pkrms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pkrms_datapath #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .channel   (channel),
        .frame_last(frame_last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .peak_level(peak_level),
        .rms_level (rms_level)
    );

endmodule

### test/peak_rms_checker.sv
// ----------------------------------------------------------------------------
// peak_rms_checker
// Watches the sample and reading channels of the peak/RMS meter and
// recomputes the per-channel attack/release envelopes, frame maxima and
// decimation. Each accepted reading is compared field by field with the
// oldest predicted reading. A failure count goes back to the testbench top.
// ----------------------------------------------------------------------------
module peak_rms_checker
    import pkrms_pkg::*;
#(
    parameter int NUM_CH = NUM_CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [CHAN_W-1:0]          channel,
    input  logic                       frame_last,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [LEVEL_W-1:0]         peak_level,
    input  logic [LEVEL_W-1:0]         rms_level,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         err_count,
    output int                         readings_due,
    output int                         readings_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] rms;
    } reading_t;

    reading_t reading_q[$];

    logic [COEF_W-1:0]  attack_k;
    logic [COEF_W-1:0]  release_k;
    logic [COEF_W-1:0]  period_k;
    logic [PEAK_W-1:0]  chan_peak [NUM_CH];
    logic [MSQ_W-1:0]   chan_msq  [NUM_CH];
    logic [PEAK_W-1:0]  frame_peak_max;
    logic [MSQ_W-1:0]   frame_msq_max;
    logic signed [DECIM_W-1:0] decim_cnt;
    logic               frame_open_q;
    int                 errs;
    int                 checked;

    function automatic logic [MSQ_W-1:0] env_follow(input logic [MSQ_W-1:0] env,
                                                    input logic [MSQ_W-1:0] target);
        longint e;
        longint t;
        longint k;
        e = env;
        t = target;
        k = (target > env) ? attack_k : release_k;
        return MSQ_W'(e + (((t - e) * k) >>> 16));
    endfunction

    function automatic logic [LEVEL_W-1:0] isqrt_floor(input logic [MSQ_W-1:0] v);
        longint r;
        longint t;
        int b;
        r = 0;
        for (b = 16; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= longint'(v))
                r = t;
        end
        return LEVEL_W'(r);
    endfunction

    task automatic clear_meter();
        int i;
        attack_k  = ATTACK_RESET;
        release_k = RELEASE_RESET;
        period_k  = PERIOD_RESET;
        for (i = 0; i < NUM_CH; i++)
        begin
            chan_peak[i] = '0;
            chan_msq[i]  = '0;
        end
        frame_peak_max = '0;
        frame_msq_max  = '0;
        decim_cnt      = '0;
        frame_open_q   = 1'b0;
        reading_q.delete();
        errs    = 0;
        checked = 0;
    endtask

    task automatic meter_step(input logic signed [SAMPLE_W-1:0] s,
                              input logic [CHAN_W-1:0] ch, input logic last);
        int         sv;
        logic [PEAK_W-1:0] mag;
        logic [MSQ_W-1:0]  sq;
        reading_t   rd;
        sv = s;
        if (!frame_open_q)
        begin
            frame_peak_max = '0;
            frame_msq_max  = '0;
            frame_open_q   = 1'b1;
        end
        mag = PEAK_W'((sv < 0) ? -sv : sv);
        sq  = MSQ_W'(longint'(mag) * longint'(mag));
        if (ch < NUM_CH)
        begin
            chan_peak[ch] = PEAK_W'(env_follow(MSQ_W'(chan_peak[ch]), MSQ_W'(mag)));
            chan_msq[ch]  = env_follow(chan_msq[ch], sq);
            if (chan_peak[ch] > frame_peak_max)
                frame_peak_max = chan_peak[ch];
            if (chan_msq[ch] > frame_msq_max)
                frame_msq_max = chan_msq[ch];
        end
        if (last)
        begin
            frame_open_q = 1'b0;
            decim_cnt = decim_cnt - 17'sd1;
            if (decim_cnt <= 17'sd0)
            begin
                decim_cnt = decim_cnt + ((period_k == 0) ? 17'sd1 : $signed({1'b0, period_k}));
                rd.peak = frame_peak_max;
                rd.rms  = isqrt_floor(frame_msq_max);
                reading_q = {reading_q, rd};
            end
        end
    endtask

    task automatic check_reading();
        reading_t want;
        if (reading_q.size() == 0)
        begin
            errs++;
            $display("%0t: unexpected reading, expected none, got peak %0d rms %0d",
                     $time, peak_level, rms_level);
        end
        else
        begin
            want = reading_q.pop_front();
            checked++;
            if (peak_level !== want.peak)
            begin
                errs++;
                $display("%0t: peak_level mismatch, expected %0d, got %0d",
                         $time, want.peak, peak_level);
            end
            if (rms_level !== want.rms)
            begin
                errs++;
                $display("%0t: rms_level mismatch, expected %0d, got %0d",
                         $time, want.rms, rms_level);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_meter();
            err_count        <= 0;
            readings_due     <= 0;
            readings_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ATTACK_COEF:   attack_k  = cfg_data;
                    REG_RELEASE_COEF:  release_k = cfg_data;
                    REG_UPDATE_PERIOD: period_k  = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                check_reading();
            if (in_valid && in_ready)
                meter_step(sample, channel, frame_last);
            readings_due     <= reading_q.size();
            err_count        <= errs;
            readings_checked <= checked;
        end
    end

    function automatic int leftover_count();
        return reading_q.size();
    endfunction

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the peak/RMS meter with directed and random sample words, framed
// and unframed, across several coefficient and update period settings and
// three idling regimes, including a long output hold-off and a drain pause.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pkrms_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 5000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       frame_last;
    logic                       out_valid;
    logic                       out_ready;
    logic [LEVEL_W-1:0]         peak_level;
    logic [LEVEL_W-1:0]         rms_level;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int err_count;
    int readings_due;
    int readings_checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq      = 0;
    int items_sent    = 0;
    int frames_sent   = 0;
    int settings_used = 0;
    int stall_cycles  = 0;

    multichannel_peak_rms_meter_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .channel    (channel),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .peak_level (peak_level),
        .rms_level  (rms_level),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    peak_rms_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .channel          (channel),
        .frame_last       (frame_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .peak_level       (peak_level),
        .rms_level        (rms_level),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .err_count        (err_count),
        .readings_due     (readings_due),
        .readings_checked (readings_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hold off the reading channel on request, otherwise idle at random
    initial
    begin : reading_sink
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen)
            begin
                seen      = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_word(input logic signed [SAMPLE_W-1:0] s,
                             input logic [CHAN_W-1:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= s;
        channel    <= ch;
        frame_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (last)
            frames_sent++;
    endtask

    // drop valid and wait until every predicted reading has been taken
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic program_meter(input logic [COEF_W-1:0] atk, input logic [COEF_W-1:0] rel,
                                 input logic [COEF_W-1:0] per);
        settle(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ATTACK_COEF;
        cfg_data  <= atk;
        @(posedge clk);
        cfg_index <= REG_RELEASE_COEF;
        cfg_data  <= rel;
        @(posedge clk);
        cfg_index <= REG_UPDATE_PERIOD;
        cfg_data  <= per;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int amp);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 4)
            return 16'sh8000;
        if (r < 8)
            return 16'sh7fff;
        if (amp == 0)
            return 16'sh0000;
        v = int'($urandom_range(2 * amp)) - amp;
        return SAMPLE_W'(v);
    endfunction

    task automatic run_phase(input int n_items);
        int stop;
        int w;
        int k;
        int amp;
        int amp_table[4];
        bit scrambled;
        amp_table = '{0, 64, 4096, 32768};
        stop = items_sent + n_items;
        while (items_sent < stop)
        begin
            if ($urandom_range(99) < 85)
            begin
                w = $urandom_range(1) ? NUM_CHANNELS_DEF : $urandom_range(1, NUM_CHANNELS_DEF);
                amp = amp_table[$urandom_range(3)];
                scrambled = ($urandom_range(99) < 20);
                for (k = 0; k < w; k++)
                    send_word(pick_sample(amp),
                              scrambled ? CHAN_W'($urandom) : CHAN_W'(k), k == w - 1);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_word(SAMPLE_W'($urandom), CHAN_W'($urandom),
                              $urandom_range(99) < 30);
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        sample     <= '0;
        channel    <= '0;
        frame_last <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_ATTACK_COEF;
        cfg_data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 22;
        recv_idle_pct <= 49;
        @(posedge clk);

        // unused register index must leave the meter unchanged
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(3);
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);

        // directed: extremes at reset coefficients, one reading per frame
        send_word(16'sh8000, 3'd0, 1'b0);
        send_word(16'sh7fff, 3'd1, 1'b0);
        send_word(16'sh0000, 3'd2, 1'b0);
        send_word(-16'sd1,   3'd3, 1'b0);
        send_word(16'sd1,    3'd4, 1'b0);
        send_word(16'sd16384, 3'd5, 1'b0);
        send_word(-16'sd16384, 3'd6, 1'b0);
        send_word(16'sh7fff, 3'd7, 1'b1);
        send_word(16'sh8000, 3'd7, 1'b1);
        send_word(16'sh0000, 3'd0, 1'b1);
        send_word(16'sh7fff, 3'd3, 1'b0);
        send_word(16'sh7fff, 3'd3, 1'b0);
        send_word(16'sh8000, 3'd3, 1'b0);
        send_word(16'sh0000, 3'd3, 1'b1);
        send_word(16'sh0000, 3'd2, 1'b1);
        send_word(16'sh5555, 3'd6, 1'b0);
        send_word(-16'sd21846, 3'd6, 1'b1);

        program_meter(16'd65535, 16'd655, 16'd1);
        hold_seq <= hold_seq + 1;
        run_phase(250);

        program_meter(16'd0, 16'd0, 16'd0);
        run_phase(150);

        send_idle_pct <= 49;
        recv_idle_pct <= 22;
        program_meter(COEF_W'($urandom), COEF_W'($urandom), 16'd3);
        run_phase(100);
        settle(0);
        run_phase(100);

        program_meter(16'd1, 16'd65535, 16'd2);
        run_phase(200);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        program_meter(16'd65535, 16'd65535, 16'd1);
        hold_seq <= hold_seq + 1;
        run_phase(150);

        program_meter(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom_range(4, 12)));
        run_phase(120);

        program_meter(16'd40000, 16'd3000, 16'd65535);
        run_phase(60);

        settle(SETTLE_CYCLES);
        $display("Sent %0d sample words in %0d frames over %0d register settings;",
                 items_sent, frames_sent, settings_used);
        $display("checked %0d readings, with idling, a long hold-off and a drain pause.",
                 readings_checked);
        if (err_count == 0 && chk.leftover_count() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
